// ===== hdl/hme_pkg.sv =====
// shared types and constants for the heightmap erosion pass
// no dependencies; all other hdl files refer to it by scoped names
`default_nettype none
package hme_pkg;

  localparam int HEIGHT_BITS    = 24;
  localparam int MAX_WIDTH      = 1024;
  localparam int COL_BITS       = $clog2(MAX_WIDTH);
  localparam int DIM_BITS       = 11;
  localparam int ROW_BITS       = 11;
  localparam int POS_BITS       = 12;
  localparam int DRAIN_BITS     = 12;
  localparam int LIMIT_BITS     = 23;
  localparam int HALF_BITS      = LIMIT_BITS - 1;
  localparam int DROP_BITS      = HEIGHT_BITS + 1;
  localparam int SUM_BITS       = HEIGHT_BITS + 4;
  localparam int CFG_DATA_BITS  = 23;
  localparam int CFG_INDEX_BITS = 2;
  localparam int NUM_CELLS      = 9;
  localparam int NUM_NBRS       = 8;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MAP_WIDTH     = 2'd0,
    REG_MAP_ROWS      = 2'd1,
    REG_EROSION_LIMIT = 2'd2
  } cfg_reg_t;

  typedef logic signed [HEIGHT_BITS-1:0] height_t;
  typedef logic signed [DROP_BITS-1:0]   drop_t;

  // 5x5 window, [row][column], column 4 is the newest
  typedef logic [4:0][4:0][HEIGHT_BITS-1:0] window_t;

  typedef logic [NUM_NBRS-1:0][HALF_BITS-1:0] gain_vec_t;

  // clamped configuration as seen by the datapath
  typedef struct packed {
    logic [DIM_BITS-1:0]   width;
    logic [DIM_BITS-1:0]   rows;
    logic [LIMIT_BITS-1:0] limit;
  } cfg_t;

  // per-result control that travels with the window
  typedef struct packed {
    logic                 last;
    logic [NUM_CELLS-1:0] inner;
  } cell_ctl_t;

  // neighbour scan order: column offset outer, row offset inner
  function automatic int nb_dy(input int n);
    int r;
    case (n)
      0, 3, 5: r = -1;
      1, 6:    r = 0;
      default: r = 1;
    endcase
    return r;
  endfunction

  function automatic int nb_dx(input int n);
    int r;
    case (n)
      0, 1, 2: r = -1;
      3, 4:    r = 0;
      default: r = 1;
    endcase
    return r;
  endfunction

  // neighbour number for a given offset
  function automatic int nb_index(input int dy, input int dx);
    int r;
    r = 0;
    for (int n = 0; n < NUM_NBRS; n++) begin
      if (nb_dy(n) == dy && nb_dx(n) == dx) r = n;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/hme_window.sv =====
// front end: raster counters, four row stores and the 5x5 window register
// depends on hme_pkg
`default_nettype none
module hme_window (
  input  logic                           clk,
  input  logic                           rst_n,
  input  hme_pkg::cfg_t                  cfg,
  input  logic                           restart,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [hme_pkg::HEIGHT_BITS-1:0] in_height,
  input  logic                           in_filler,
  output logic                           win_valid,
  input  logic                           win_ready,
  output hme_pkg::window_t               win,
  output hme_pkg::cell_ctl_t             win_ctl
);

  logic [hme_pkg::COL_BITS-1:0]   col_cnt_r, col_cnt_nxt;
  logic [hme_pkg::ROW_BITS-1:0]   row_cnt_r, row_cnt_nxt;
  logic [hme_pkg::DRAIN_BITS-1:0] drain_cnt_r, drain_cnt_nxt;

  logic                              draining, take, drain_end, ready_1, ready_2;
  logic [hme_pkg::DRAIN_BITS-1:0]    span;
  logic [hme_pkg::HEIGHT_BITS-1:0]   sample;
  logic signed [hme_pkg::POS_BITS-1:0] cell_r, cell_c;

  // stage 1
  logic                                v1_r, emit1_r, last1_r;
  logic [1:0]                          rp1_r;
  logic [hme_pkg::HEIGHT_BITS-1:0]     smp1_r;
  logic signed [hme_pkg::POS_BITS-1:0] cr1_r, cc1_r;
  logic [hme_pkg::HEIGHT_BITS-1:0]     rd_r [4];

  // stage 2
  logic                 v2_r, emit2_r;
  hme_pkg::window_t     win_r, win_nxt;
  hme_pkg::cell_ctl_t   ctl2_r, ctl_nxt;

  assign ready_2  = !v2_r || !emit2_r || win_ready;
  assign ready_1  = !v1_r || ready_2;
  assign in_ready = ready_1;

  // stream position bookkeeping
  assign draining  = row_cnt_r >= cfg.rows;
  assign span      = hme_pkg::DRAIN_BITS'({cfg.width, 1'b0}) + hme_pkg::DRAIN_BITS'(2);
  assign take      = in_valid && in_ready && (draining || !in_filler);
  assign sample    = draining ? '0 : in_height;
  assign drain_end = draining &&
                     ((drain_cnt_r + hme_pkg::DRAIN_BITS'(1)) >= span);

  always_comb begin
    logic [hme_pkg::DIM_BITS-1:0] col_inc;
    col_inc       = hme_pkg::DIM_BITS'(col_cnt_r) + hme_pkg::DIM_BITS'(1);
    col_cnt_nxt   = col_cnt_r;
    row_cnt_nxt   = row_cnt_r;
    drain_cnt_nxt = drain_cnt_r;
    if (restart) begin
      col_cnt_nxt   = '0;
      row_cnt_nxt   = '0;
      drain_cnt_nxt = '0;
    end else if (take) begin
      if (col_inc >= cfg.width) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = row_cnt_r + hme_pkg::ROW_BITS'(1);
      end else begin
        col_cnt_nxt = col_inc[hme_pkg::COL_BITS-1:0];
      end
      if (draining) drain_cnt_nxt = drain_cnt_r + hme_pkg::DRAIN_BITS'(1);
      if (drain_end) begin
        col_cnt_nxt   = '0;
        row_cnt_nxt   = '0;
        drain_cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      drain_cnt_r <= '0;
    end else begin
      col_cnt_r   <= col_cnt_nxt;
      row_cnt_r   <= row_cnt_nxt;
      drain_cnt_r <= drain_cnt_nxt;
    end
  end

  // position of the cell centred in the window after this shift
  always_comb begin
    logic signed [hme_pkg::POS_BITS-1:0] row_s, col_s, w_s;
    row_s = $signed({1'b0, row_cnt_r});
    col_s = $signed(hme_pkg::POS_BITS'(col_cnt_r));
    w_s   = $signed({1'b0, cfg.width});
    if (col_cnt_r >= hme_pkg::COL_BITS'(2)) begin
      cell_r = row_s - hme_pkg::POS_BITS'(2);
      cell_c = col_s - hme_pkg::POS_BITS'(2);
    end else begin
      cell_r = row_s - hme_pkg::POS_BITS'(3);
      cell_c = col_s + w_s - hme_pkg::POS_BITS'(2);
    end
  end

  // one row bank per row modulo 4, read at the current column
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [hme_pkg::HEIGHT_BITS-1:0] bank [hme_pkg::MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (take) begin
        if (row_cnt_r[1:0] == 2'(b)) bank[col_cnt_r] <= sample;
        rd_r[b] <= bank[col_cnt_r];
      end
    end
  end

  // stage 1 control and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ready_1) begin
      v1_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_1 && take) begin
      rp1_r   <= row_cnt_r[1:0];
      smp1_r  <= sample;
      cr1_r   <= cell_r;
      cc1_r   <= cell_c;
      emit1_r <= !cell_r[hme_pkg::POS_BITS-1];
      last1_r <= drain_end;
    end
  end

  // window shift and interior flags
  always_comb begin
    logic [1:0] bsel;
    logic [2:0] row_ok, col_ok;
    logic signed [hme_pkg::POS_BITS-1:0] rr, cc, h_lim, w_lim;
    h_lim = $signed({1'b0, cfg.rows}) - hme_pkg::POS_BITS'(2);
    w_lim = $signed({1'b0, cfg.width}) - hme_pkg::POS_BITS'(2);
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 4; j++) win_nxt[i][j] = win_r[i][j+1];
      if (i < 4) begin
        bsel = rp1_r + 2'(i);
        win_nxt[i][4] = rd_r[bsel];
      end else begin
        win_nxt[i][4] = smp1_r;
      end
    end
    for (int o = 0; o < 3; o++) begin
      rr = cr1_r + hme_pkg::POS_BITS'(o) - hme_pkg::POS_BITS'(1);
      cc = cc1_r + hme_pkg::POS_BITS'(o) - hme_pkg::POS_BITS'(1);
      row_ok[o] = (rr >= hme_pkg::POS_BITS'(1)) && (rr <= h_lim);
      col_ok[o] = (cc >= hme_pkg::POS_BITS'(1)) && (cc <= w_lim);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) ctl_nxt.inner[i*3+j] = row_ok[i] && col_ok[j];
    end
    ctl_nxt.last = last1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r    <= 1'b0;
      emit2_r <= 1'b0;
      win_r   <= '0;
    end else if (ready_2) begin
      v2_r <= v1_r;
      if (v1_r) begin
        win_r   <= win_nxt;
        emit2_r <= emit1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_2 && v1_r) ctl2_r <= ctl_nxt;
  end

  assign win_valid = v2_r && emit2_r;
  assign win       = win_r;
  assign win_ctl   = ctl2_r;

endmodule
`default_nettype wire

// ===== hdl/hme_cell_calc.sv =====
// drop, steepest neighbour and moved half for the nine cells around the centre
// three register stages; depends on hme_pkg
`default_nettype none
module hme_cell_calc (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [hme_pkg::LIMIT_BITS-1:0]    limit,
  input  logic                              win_valid,
  output logic                              win_ready,
  input  hme_pkg::window_t                  win,
  input  hme_pkg::cell_ctl_t                win_ctl,
  output logic                              gain_valid,
  input  logic                              gain_ready,
  output logic [hme_pkg::HEIGHT_BITS-1:0]   centre,
  output logic [hme_pkg::HALF_BITS-1:0]     loss,
  output hme_pkg::gain_vec_t                gains,
  output logic                              last
);

  typedef struct packed {
    logic [2:0]     idx;
    hme_pkg::drop_t val;
  } pick_t;

  // later candidate wins only on a strictly larger drop
  function automatic pick_t pick_better(input pick_t a, input pick_t b);
    pick_t r;
    r = ($signed(b.val) > $signed(a.val)) ? b : a;
    return r;
  endfunction

  logic ready_3, ready_4, ready_5;

  // stage 3: all drops
  logic                            v3_r;
  hme_pkg::drop_t                  d3_r [hme_pkg::NUM_CELLS][hme_pkg::NUM_NBRS];
  hme_pkg::drop_t                  d3_nxt [hme_pkg::NUM_CELLS][hme_pkg::NUM_NBRS];
  logic [hme_pkg::HEIGHT_BITS-1:0] ctr3_r;
  hme_pkg::cell_ctl_t              ctl3_r;

  // stage 4: steepest neighbour
  logic                            v4_r;
  pick_t                           p4_r [hme_pkg::NUM_CELLS];
  pick_t                           p4_nxt [hme_pkg::NUM_CELLS];
  logic [hme_pkg::NUM_CELLS-1:0]   pos4_r, pos4_nxt;
  logic [hme_pkg::HEIGHT_BITS-1:0] ctr4_r;
  hme_pkg::cell_ctl_t              ctl4_r;

  // stage 5: moved halves
  logic                            v5_r, last5_r;
  logic [hme_pkg::HALF_BITS-1:0]   half [hme_pkg::NUM_CELLS];
  logic [hme_pkg::HALF_BITS-1:0]   loss5_r, loss_nxt;
  hme_pkg::gain_vec_t              gain5_r, gain_nxt;
  logic [hme_pkg::HEIGHT_BITS-1:0] ctr5_r;

  assign ready_5   = !v5_r || gain_ready;
  assign ready_4   = !v4_r || ready_5;
  assign ready_3   = !v3_r || ready_4;
  assign win_ready = ready_3;

  // drop from each cell to each of its neighbours
  for (genvar c = 0; c < hme_pkg::NUM_CELLS; c++) begin : g_cell
    localparam int CI = 1 + c / 3;
    localparam int CJ = 1 + c % 3;
    for (genvar n = 0; n < hme_pkg::NUM_NBRS; n++) begin : g_nbr
      localparam int NI = CI + hme_pkg::nb_dy(n);
      localparam int NJ = CJ + hme_pkg::nb_dx(n);
      assign d3_nxt[c][n] = $signed({win[CI][CJ][hme_pkg::HEIGHT_BITS-1], win[CI][CJ]}) -
                            $signed({win[NI][NJ][hme_pkg::HEIGHT_BITS-1], win[NI][NJ]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (ready_3) v3_r <= win_valid;
  end

  always_ff @(posedge clk) begin
    if (ready_3 && win_valid) begin
      d3_r   <= d3_nxt;
      ctr3_r <= win[2][2];
      ctl3_r <= win_ctl;
    end
  end

  // argmax over eight neighbours as a pairwise tree, earlier side on ties
  always_comb begin
    pick_t leaf [hme_pkg::NUM_NBRS];
    pick_t l1 [4];
    pick_t l2 [2];
    pick_t top;
    for (int c = 0; c < hme_pkg::NUM_CELLS; c++) begin
      for (int n = 0; n < hme_pkg::NUM_NBRS; n++) begin
        leaf[n].idx = 3'(n);
        leaf[n].val = d3_r[c][n];
      end
      for (int k = 0; k < 4; k++) l1[k] = pick_better(leaf[2*k], leaf[2*k+1]);
      for (int k = 0; k < 2; k++) l2[k] = pick_better(l1[2*k], l1[2*k+1]);
      top = pick_better(l2[0], l2[1]);
      p4_nxt[c]   = top;
      pos4_nxt[c] = $signed(top.val) > $signed(hme_pkg::DROP_BITS'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (ready_4) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (ready_4 && v3_r) begin
      p4_r   <= p4_nxt;
      pos4_r <= pos4_nxt;
      ctr4_r <= ctr3_r;
      ctl4_r <= ctl3_r;
    end
  end

  // amount limited, then halved
  always_comb begin
    logic [hme_pkg::LIMIT_BITS-1:0] amt;
    for (int c = 0; c < hme_pkg::NUM_CELLS; c++) begin
      if ($signed(p4_r[c].val) > $signed({2'b00, limit})) amt = limit;
      else amt = p4_r[c].val[hme_pkg::LIMIT_BITS-1:0];
      half[c] = amt[hme_pkg::LIMIT_BITS-1:1];
    end
  end

  assign loss_nxt = (ctl4_r.inner[4] && pos4_r[4]) ? half[4] : '0;

  // a neighbour feeds the centre only when the centre is its steepest target
  for (genvar c = 0; c < hme_pkg::NUM_CELLS; c++) begin : g_gain
    if (c != 4) begin : g_nb
      localparam int CI = 1 + c / 3;
      localparam int CJ = 1 + c % 3;
      localparam int NC = hme_pkg::nb_index(2 - CI, 2 - CJ);
      localparam int K  = (c < 4) ? c : c - 1;
      assign gain_nxt[K] = (ctl4_r.inner[c] && pos4_r[c] && p4_r[c].idx == 3'(NC)) ?
                           half[c] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (ready_5) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (ready_5 && v4_r) begin
      loss5_r <= loss_nxt;
      gain5_r <= gain_nxt;
      ctr5_r  <= ctr4_r;
      last5_r <= ctl4_r.last;
    end
  end

  assign gain_valid = v5_r;
  assign centre     = ctr5_r;
  assign loss       = loss5_r;
  assign gains      = gain5_r;
  assign last       = last5_r;

endmodule
`default_nettype wire

// ===== hdl/hme_sum.sv =====
// subtracts its loss from the centre, adds the received halves, saturates into the output register
// two register stages; depends on hme_pkg
`default_nettype none
module hme_sum (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            gain_valid,
  output logic                            gain_ready,
  input  logic [hme_pkg::HEIGHT_BITS-1:0] centre,
  input  logic [hme_pkg::HALF_BITS-1:0]   loss,
  input  hme_pkg::gain_vec_t              gains,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [hme_pkg::HEIGHT_BITS-1:0] out_height,
  output logic                            out_last
);

  localparam int EXT = hme_pkg::SUM_BITS - hme_pkg::HEIGHT_BITS;
  localparam int TOP = hme_pkg::SUM_BITS - hme_pkg::HEIGHT_BITS + 1;

  logic ready_6, ready_7;

  logic                                v6_r, last6_r;
  logic signed [hme_pkg::SUM_BITS-1:0] p0_r, p1_r, p2_r, p0_nxt, p1_nxt, p2_nxt;

  logic                            v7_r, last7_r;
  logic [hme_pkg::HEIGHT_BITS-1:0] res7_r, res_nxt;

  assign ready_7    = !v7_r || out_ready;
  assign ready_6    = !v6_r || ready_7;
  assign gain_ready = ready_6;

  // partial sums
  assign p0_nxt = $signed({{EXT{centre[hme_pkg::HEIGHT_BITS-1]}}, centre}) -
                  $signed(hme_pkg::SUM_BITS'(loss));
  assign p1_nxt = $signed(hme_pkg::SUM_BITS'(gains[0]) + hme_pkg::SUM_BITS'(gains[1]) +
                          hme_pkg::SUM_BITS'(gains[2]) + hme_pkg::SUM_BITS'(gains[3]));
  assign p2_nxt = $signed(hme_pkg::SUM_BITS'(gains[4]) + hme_pkg::SUM_BITS'(gains[5]) +
                          hme_pkg::SUM_BITS'(gains[6]) + hme_pkg::SUM_BITS'(gains[7]));

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (ready_6) v6_r <= gain_valid;
  end

  always_ff @(posedge clk) begin
    if (ready_6 && gain_valid) begin
      p0_r    <= p0_nxt;
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      last6_r <= last;
    end
  end

  // final add and saturation to the height range
  always_comb begin
    logic signed [hme_pkg::SUM_BITS-1:0] total;
    logic [TOP-1:0] hi;
    total = p0_r + p1_r + p2_r;
    hi    = total[hme_pkg::SUM_BITS-1:hme_pkg::HEIGHT_BITS-1];
    if (hi == '0 || hi == '1) res_nxt = total[hme_pkg::HEIGHT_BITS-1:0];
    else if (total[hme_pkg::SUM_BITS-1]) res_nxt = {1'b1, {(hme_pkg::HEIGHT_BITS-1){1'b0}}};
    else res_nxt = {1'b0, {(hme_pkg::HEIGHT_BITS-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (ready_7) v7_r <= v6_r;
  end

  always_ff @(posedge clk) begin
    if (ready_7 && v6_r) begin
      res7_r  <= res_nxt;
      last7_r <= last6_r;
    end
  end

  assign out_valid  = v7_r;
  assign out_height = res7_r;
  assign out_last   = last7_r;

endmodule
`default_nettype wire

// ===== hdl/heightmap_erosion_pass.sv =====
// heightmap_erosion_pass: one thermal erosion pass over a raster heightmap stream
// throughput: one transaction per cycle, stalls only under output backpressure
// path: the transaction that completes a cell's 5x5 window passes stage 1, stage 2, the
//   cell_calc stages and the sum stages into the output register (2*W+2 stream positions after its own sample)
// reset: counters and pipeline valids clear, registers return to 1024, 1024, 26;
//   the row stores are not cleared, so no clearing pass is needed
// depends on hme_pkg, hme_window, hme_cell_calc, hme_sum
`default_nettype none
module heightmap_erosion_pass (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [hme_pkg::HEIGHT_BITS-1:0]     in_height_in,
  input  logic                                in_filler,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hme_pkg::HEIGHT_BITS-1:0]     out_height_out,
  output logic                                out_frame_last,
  input  logic                                cfg_we,
  input  logic [hme_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [hme_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam logic [hme_pkg::DIM_BITS-1:0] DIM_LOW   = hme_pkg::DIM_BITS'(3);
  localparam logic [hme_pkg::DIM_BITS-1:0] WIDTH_TOP = hme_pkg::DIM_BITS'(hme_pkg::MAX_WIDTH);
  localparam logic [hme_pkg::DIM_BITS-1:0] ROWS_TOP  = hme_pkg::DIM_BITS'(1024);

  function automatic logic [hme_pkg::DIM_BITS-1:0] clamp_dim(
    input logic [hme_pkg::DIM_BITS-1:0] v,
    input logic [hme_pkg::DIM_BITS-1:0] top
  );
    logic [hme_pkg::DIM_BITS-1:0] r;
    if (v < DIM_LOW) r = DIM_LOW;
    else if (v > top) r = top;
    else r = v;
    return r;
  endfunction

  hme_pkg::cfg_t cfg_r;
  logic          restart;

  logic                     win_valid, win_ready;
  hme_pkg::window_t         win;
  hme_pkg::cell_ctl_t       win_ctl;

  logic                            gain_valid, gain_ready, gain_last;
  logic [hme_pkg::HEIGHT_BITS-1:0] centre;
  logic [hme_pkg::HALF_BITS-1:0]   loss;
  hme_pkg::gain_vec_t              gains;

  // a new dimension restarts the frame
  assign restart = cfg_we &&
                   (hme_pkg::cfg_reg_t'(cfg_index) == hme_pkg::REG_MAP_WIDTH ||
                    hme_pkg::cfg_reg_t'(cfg_index) == hme_pkg::REG_MAP_ROWS);

  // configuration registers, dimensions stored already clamped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width <= WIDTH_TOP;
      cfg_r.rows  <= ROWS_TOP;
      cfg_r.limit <= hme_pkg::LIMIT_BITS'(26);
    end else if (cfg_we) begin
      case (hme_pkg::cfg_reg_t'(cfg_index))
        hme_pkg::REG_MAP_WIDTH: begin
          cfg_r.width <= clamp_dim(cfg_data[hme_pkg::DIM_BITS-1:0], WIDTH_TOP);
        end
        hme_pkg::REG_MAP_ROWS: begin
          cfg_r.rows <= clamp_dim(cfg_data[hme_pkg::DIM_BITS-1:0], ROWS_TOP);
        end
        hme_pkg::REG_EROSION_LIMIT: begin
          cfg_r.limit <= cfg_data[hme_pkg::LIMIT_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  hme_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .restart   (restart),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_height (in_height_in),
    .in_filler (in_filler),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .win       (win),
    .win_ctl   (win_ctl)
  );

  hme_cell_calc u_cell_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .limit      (cfg_r.limit),
    .win_valid  (win_valid),
    .win_ready  (win_ready),
    .win        (win),
    .win_ctl    (win_ctl),
    .gain_valid (gain_valid),
    .gain_ready (gain_ready),
    .centre     (centre),
    .loss       (loss),
    .gains      (gains),
    .last       (gain_last)
  );

  hme_sum u_sum (
    .clk        (clk),
    .rst_n      (rst_n),
    .gain_valid (gain_valid),
    .gain_ready (gain_ready),
    .centre     (centre),
    .loss       (loss),
    .gains      (gains),
    .last       (gain_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_height (out_height_out),
    .out_last   (out_frame_last)
  );

endmodule
`default_nettype wire

// ===== sim/heightmap_erosion_pass_checker.sv =====
// erosion pass checker: watches config writes and both channels, predicts each eroded cell
// and compares it with what the block delivers; depends on hme_pkg
`timescale 1ns / 1ps
`default_nettype none
module heightmap_erosion_pass_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [hme_pkg::HEIGHT_BITS-1:0]    in_height_in,
  input  logic                               in_filler,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [hme_pkg::HEIGHT_BITS-1:0]    out_height_out,
  input  logic                               out_frame_last,
  input  logic                               cfg_we,
  input  logic [hme_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [hme_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                 fail_count,
  output int                                 pending
);
  import hme_pkg::*;

  typedef struct {
    logic [HEIGHT_BITS-1:0] height;
    logic                   last;
  } cell_result_t;

  localparam longint HMAX = (64'sd1 <<< (HEIGHT_BITS - 1)) - 1;
  localparam longint HMIN = -HMAX - 1;

  cell_result_t eroded_q[$];

  // predictor copy of configuration and stream state
  logic [DIM_BITS-1:0]   width_reg;
  logic [DIM_BITS-1:0]   rows_reg;
  logic [LIMIT_BITS-1:0] limit_reg;
  longint                line_mem[4*MAX_WIDTH];
  longint                win[5][5];
  int                    col_pos;
  int                    row_pos;
  int                    drain_pos;
  int                    cell_row;
  int                    cell_col;
  int                    frame_cols;
  int                    frame_rows;

  assign pending = eroded_q.size();

  function automatic int clamp_dim(input int v, input int top);
    if (v < 3) return 3;
    if (v > top) return top;
    return v;
  endfunction

  function automatic bit inner_cell(input int i, input int j);
    int rr;
    int cc;
    rr = cell_row - 2 + i;
    cc = cell_col - 2 + j;
    return rr >= 1 && rr <= frame_rows - 2 && cc >= 1 && cc <= frame_cols - 2;
  endfunction

  // half of the amount that window cell (i, j) sheds, and the neighbour it goes to
  function automatic longint shed_half(input int i, input int j, output int ti, output int tj);
    longint best;
    longint d;
    longint amt;
    best = 0;
    ti = -1;
    tj = -1;
    for (int dx = -1; dx <= 1; dx++) begin
      for (int dy = -1; dy <= 1; dy++) begin
        if (dx != 0 || dy != 0) begin
          d = win[i][j] - win[i+dy][j+dx];
          if (d > best) begin
            best = d;
            ti = i + dy;
            tj = j + dx;
          end
        end
      end
    end
    if (best <= 0) return 0;
    amt = (best < longint'(limit_reg)) ? best : longint'(limit_reg);
    return amt / 2;
  endfunction

  // advance the stream by one transaction and queue the eroded cell it completes
  function automatic void erode_step(input logic [HEIGHT_BITS-1:0] h, input logic f);
    int w;
    int rh;
    int cp;
    int ti;
    int tj;
    bit draining;
    bit last;
    longint sample;
    longint col[5];
    longint res;
    longint half;
    cell_result_t r;
    w = clamp_dim(int'(width_reg), MAX_WIDTH);
    rh = clamp_dim(int'(rows_reg), 1024);
    draining = row_pos >= rh;
    last = 0;
    sample = 0;
    if (!draining) begin
      if (f) return;
      sample = longint'($signed(h));
    end
    cp = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
    for (int k = 0; k < 4; k++) col[k] = line_mem[((row_pos + k) & 3) * MAX_WIDTH + cp];
    col[4] = sample;
    line_mem[(row_pos & 3) * MAX_WIDTH + cp] = sample;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 4; j++) win[i][j] = win[i][j+1];
      win[i][4] = col[i];
    end
    frame_cols = w;
    frame_rows = rh;
    if (col_pos >= 2) begin
      cell_row = row_pos - 2;
      cell_col = col_pos - 2;
    end else begin
      cell_row = row_pos - 3;
      cell_col = col_pos + w - 2;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (draining) begin
      drain_pos++;
      if (drain_pos >= 2 * w + 2) begin
        last = 1;
        col_pos = 0;
        row_pos = 0;
        drain_pos = 0;
      end
    end
    if (cell_row < 0) return;
    res = win[2][2];
    if (inner_cell(2, 2)) res -= shed_half(2, 2, ti, tj);
    for (int i = 1; i <= 3; i++) begin
      for (int j = 1; j <= 3; j++) begin
        if ((i != 2 || j != 2) && inner_cell(i, j)) begin
          half = shed_half(i, j, ti, tj);
          if (ti == 2 && tj == 2) res += half;
        end
      end
    end
    if (res > HMAX) res = HMAX;
    if (res < HMIN) res = HMIN;
    r.height = res[HEIGHT_BITS-1:0];
    r.last = last;
    eroded_q.push_back(r);
  endfunction

  // track configuration and input transactions
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg <= 1024;
      rows_reg <= 1024;
      limit_reg <= 26;
      col_pos = 0;
      row_pos = 0;
      drain_pos = 0;
      for (int i = 0; i < 5; i++) for (int j = 0; j < 5; j++) win[i][j] = 0;
      for (int k = 0; k < 4 * MAX_WIDTH; k++) line_mem[k] = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MAP_WIDTH: begin
            width_reg <= cfg_data[DIM_BITS-1:0];
            col_pos = 0;
            row_pos = 0;
            drain_pos = 0;
          end
          REG_MAP_ROWS: begin
            rows_reg <= cfg_data[DIM_BITS-1:0];
            col_pos = 0;
            row_pos = 0;
            drain_pos = 0;
          end
          REG_EROSION_LIMIT: limit_reg <= cfg_data[LIMIT_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) erode_step(in_height_in, in_filler);
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    cell_result_t e;
    if (!rst_n) begin
      fail_count <= 0;
    end else if (out_valid && out_ready) begin
      if (eroded_q.size() == 0) begin
        if (fail_count < 10) $display("unexpected result: height %h last %b",
                                      out_height_out, out_frame_last);
        fail_count <= fail_count + 1;
      end else begin
        e = eroded_q.pop_front();
        if (e.height !== out_height_out || e.last !== out_frame_last) begin
          if (fail_count < 10) $display("mismatch: expected height %h last %b, got %h %b",
                                        e.height, e.last, out_height_out, out_frame_last);
          fail_count <= fail_count + 1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== sim/heightmap_erosion_pass_tb.sv =====
// top of the erosion pass testbench: clock, reset, stimulus frames, flow control, verdict
// depends on hme_pkg, heightmap_erosion_pass and heightmap_erosion_pass_checker
`timescale 1ns / 1ps
`default_nettype none
module heightmap_erosion_pass_tb;
  import hme_pkg::*;

  typedef struct {
    logic [HEIGHT_BITS-1:0] height;
    logic                   filler;
  } sample_t;

  logic                      clk = 0;
  logic                      rst_n = 0;
  logic                      in_valid = 0;
  logic                      in_ready;
  logic [HEIGHT_BITS-1:0]    in_height_in = '0;
  logic                      in_filler = 0;
  logic                      out_valid;
  logic                      out_ready = 0;
  logic [HEIGHT_BITS-1:0]    out_height_out;
  logic                      out_frame_last;
  logic                      cfg_we = 0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  int                        fail_count;
  int                        pending;

  sample_t   sample_q[$];
  int        burst_left = 0;
  int        gap_left = 0;
  bit        hold_off = 0;
  int        ready_mode = 0;
  int        sent_items = 0;
  int        cur_w;
  int        cur_r;

  always #1 clk = ~clk;

  heightmap_erosion_pass uut (.*);

  heightmap_erosion_pass_checker chk (.*);

  // sender: bursts with random gaps, payload held until accepted
  always @(posedge clk) begin
    sample_t s;
    if (rst_n && (!in_valid || in_ready)) begin
      if (gap_left > 0 || sample_q.size() == 0) begin
        in_valid <= 0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        s = sample_q.pop_front();
        in_valid <= 1;
        in_height_in <= s.height;
        in_filler <= s.filler;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: stall pattern that changes mode now and then
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) ready_mode <= $urandom_range(0, 2);
    if (hold_off) out_ready <= 0;
    else if (ready_mode == 0) out_ready <= 1;
    else if (ready_mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= ($urandom_range(0, 2) == 0);
  end

  // one long receiver hold-off while the sender keeps offering
  initial begin
    wait (sample_q.size() > 200);
    hold_off = 1;
    repeat (400) @(posedge clk);
    hold_off = 0;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int eff_dim(input int v, input int top);
    return (v < 3) ? 3 : (v > top) ? top : v;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input int value);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_BITS'(value);
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_MAP_WIDTH) cur_w = eff_dim(value & 'h7ff, MAX_WIDTH);
    if (idx == REG_MAP_ROWS) cur_r = eff_dim(value & 'h7ff, 1024);
  endtask

  // wait for the block to drain everything in flight
  task automatic settle();
    wait (sample_q.size() == 0 && !in_valid && pending == 0);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [HEIGHT_BITS-1:0] pick_height(input int mode, input int base);
    case (mode)
      0: return HEIGHT_BITS'($urandom);
      1: return HEIGHT_BITS'(base + int'($urandom_range(0, 300)) - 150);
      2: return ($urandom_range(0, 1) != 0) ?
                HEIGHT_BITS'(24'h7fffff - $urandom_range(0, 60)) :
                HEIGHT_BITS'(24'h800000 + $urandom_range(0, 60));
      default: return HEIGHT_BITS'(base + int'($urandom_range(0, 40)));
    endcase
  endfunction

  // queue one frame of samples plus its drain transactions
  task automatic queue_frame(input int mode, input int filler_pct);
    int base;
    sample_t s;
    base = $urandom;
    for (int n = 0; n < cur_w * cur_r; n++) begin
      while ($urandom_range(0, 99) < filler_pct) begin
        s.height = HEIGHT_BITS'($urandom);
        s.filler = 1;
        sample_q.push_back(s);
      end
      s.height = pick_height(mode, base);
      s.filler = 0;
      sample_q.push_back(s);
      sent_items++;
    end
    for (int n = 0; n < 2 * cur_w + 2; n++) begin
      s.height = HEIGHT_BITS'($urandom);
      s.filler = 1'($urandom_range(0, 1));
      sample_q.push_back(s);
      sent_items++;
    end
  endtask

  initial begin
    int lim;
    cur_w = 1024;
    cur_r = 1024;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // directed: smallest frame with extreme heights, then limit extremes
    write_reg(REG_MAP_WIDTH, 0);
    write_reg(REG_MAP_ROWS, 2);
    queue_frame(2, 20);
    settle();
    write_reg(REG_EROSION_LIMIT, 0);
    write_reg(REG_MAP_WIDTH, 4);
    write_reg(REG_MAP_ROWS, 3);
    queue_frame(0, 0);
    settle();
    write_reg(REG_EROSION_LIMIT, 'h7fffff);
    queue_frame(0, 0);
    queue_frame(2, 0);
    settle();

    // a longer frame, long enough to see the receiver hold-off
    write_reg(REG_MAP_WIDTH, 60);
    write_reg(REG_MAP_ROWS, 5);
    write_reg(REG_EROSION_LIMIT, 26);
    queue_frame(1, 2);
    settle();
    write_reg(REG_MAP_ROWS, 'h7ff);
    write_reg(REG_MAP_WIDTH, 1025);
    write_reg(REG_MAP_WIDTH, 5);
    write_reg(REG_MAP_ROWS, 4);
    queue_frame(3, 5);
    settle();

    // random frames, mostly small
    while (sent_items < 1150) begin
      if ($urandom_range(0, 2) != 0) begin
        write_reg(REG_MAP_WIDTH, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                             : $urandom_range(3, 10));
        write_reg(REG_MAP_ROWS, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                            : $urandom_range(3, 8));
      end
      case ($urandom_range(0, 4))
        0: lim = 0;
        1: lim = 'h7fffff;
        2: lim = $urandom_range(1, 64);
        3: lim = $urandom_range(0, 'h7fffff);
        default: lim = $urandom_range(1, 2000);
      endcase
      write_reg(REG_EROSION_LIMIT, lim);
      queue_frame($urandom_range(0, 3), $urandom_range(0, 10));
      if ($urandom_range(0, 1) != 0) queue_frame($urandom_range(0, 3), 5);
      settle();
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
